>>> hdl/ip_destination_classifier_unit_defines.svh
// assertion macros for the ip destination classifier
// expects clk and rst_n in the scope where a macro is used
`ifndef IP_DESTINATION_CLASSIFIER_UNIT_DEFINES_SVH
`define IP_DESTINATION_CLASSIFIER_UNIT_DEFINES_SVH

// same-cycle implication, ignored while reset is asserted
`define IPDC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ipdc assertion failed");

// next-cycle implication, ignored while reset is asserted
`define IPDC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ipdc assertion failed");

`endif

>>> hdl/ipdc_pkg.sv
// types and classification functions for the ip destination classifier
// no dependencies
`default_nettype none

package ipdc_pkg;

  typedef enum logic [2:0] {
    V_ALLOWED      = 3'd0,
    V_LOOPBACK     = 3'd1,
    V_PRIVATE      = 3'd2,
    V_LINK_LOCAL   = 3'd3,
    V_UNIQUE_LOCAL = 3'd4,
    V_MCAST_BCAST  = 3'd5,
    V_UNSPECIFIED  = 3'd6,
    V_RESERVED     = 3'd7
  } verdict_t;

  localparam int unsigned ADDR_W = 64;
  localparam int unsigned V4_W   = 32;

  // ipv4 special-use blocks, first match wins
  function automatic verdict_t classify_v4(input logic [V4_W-1:0] a);
    logic [7:0] o1;
    logic [7:0] o2;
    logic [7:0] o3;
    verdict_t   v;
    o1 = a[31:24];
    o2 = a[23:16];
    o3 = a[15:8];
    if (a == 32'h0000_0000) begin
      v = V_UNSPECIFIED;
    end else if (o1 == 8'd127) begin
      v = V_LOOPBACK;
    end else if (o1 == 8'd10) begin
      v = V_PRIVATE;
    end else if (o1 == 8'd172 && o2[7:4] == 4'h1) begin
      v = V_PRIVATE;
    end else if (o1 == 8'd192 && o2 == 8'd168) begin
      v = V_PRIVATE;
    end else if (o1 == 8'd169 && o2 == 8'd254) begin
      v = V_LINK_LOCAL;
    end else if (o1 == 8'd100 && o2[7:6] == 2'b01) begin
      v = V_PRIVATE;
    end else if (o1[7:4] == 4'hE) begin
      v = V_MCAST_BCAST;
    end else if (a == 32'hFFFF_FFFF) begin
      v = V_MCAST_BCAST;
    end else if (o1 == 8'd0) begin
      v = V_RESERVED;
    end else if (o1 == 8'd192 && o2 == 8'd0) begin
      v = V_RESERVED;
    end else if (o1 == 8'd192 && o2 == 8'd88 && o3 == 8'd99) begin
      v = V_RESERVED;
    end else if (o1 == 8'd198 && o2[7:1] == 7'd9) begin
      v = V_RESERVED;
    end else if (o1 == 8'd198 && o2 == 8'd51) begin
      v = V_RESERVED;
    end else if (o1 == 8'd203 && o2 == 8'd0) begin
      v = V_RESERVED;
    end else if (o1[7:4] == 4'hF) begin
      v = V_RESERVED;
    end else begin
      v = V_ALLOWED;
    end
    return v;
  endfunction

  // ipv6 scopes, then embedded ipv4 forms, then global unicast checks
  function automatic verdict_t classify_v6(input logic [ADDR_W-1:0] hi,
                                           input logic [ADDR_W-1:0] lo);
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    logic       hi_zero;
    verdict_t   v;
    b0      = hi[63:56];
    b1      = hi[55:48];
    b2      = hi[47:40];
    b3      = hi[39:32];
    hi_zero = (hi == '0);
    if (hi_zero && lo == '0) begin
      v = V_UNSPECIFIED;
    end else if (hi_zero && lo == 64'd1) begin
      v = V_LOOPBACK;
    end else if (b0 == 8'hFF) begin
      v = V_MCAST_BCAST;
    end else if (b0 == 8'hFE && b1[7:6] == 2'b10) begin
      v = V_LINK_LOCAL;
    end else if (b0[7:1] == 7'h7E) begin
      v = V_UNIQUE_LOCAL;
    end else if (hi_zero && lo[63:32] == 32'h0000_FFFF) begin
      v = classify_v4(lo[31:0]);
    end else if (b0 == 8'h20 && b1 == 8'h02) begin
      v = classify_v4(hi[47:16]);
    end else if (b0 == 8'h00 && b1 == 8'h64 && b2 == 8'hFF && b3 == 8'h9B) begin
      v = classify_v4(lo[31:0]);
    end else if (b0[7:5] != 3'b001) begin
      v = V_RESERVED;
    end else if (b0 == 8'h20 && b1 == 8'h01 &&
                 (b2[7:1] == 7'd0 || (b2 == 8'h0D && b3 == 8'hB8))) begin
      v = V_RESERVED;
    end else if (b0 == 8'h3F && b1 == 8'hFE) begin
      v = V_RESERVED;
    end else if (b0 == 8'h3F && b1 == 8'hFF && b2[7:4] == 4'h0) begin
      v = V_RESERVED;
    end else begin
      v = V_ALLOWED;
    end
    return v;
  endfunction

endpackage

`default_nettype wire

>>> hdl/ip_destination_classifier_unit.sv
// ip destination classifier top level: input register, verdict logic, result register
// depends on ipdc_pkg and ip_destination_classifier_unit_defines.svh
// a taken beat passes through the input register and then the result register, where its
// verdict is strobed on out_valid
// throughput: one address per cycle, busy is never raised; the verdict logic between the
// two registers is one pass of fixed compares
// reset (rst_n low, synchronous) clears both valid flags; payload is not reset
// results cannot be held off, each verdict is shown for exactly one cycle
`default_nettype none

`include "ip_destination_classifier_unit_defines.svh"

module ip_destination_classifier_unit
  import ipdc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output      logic              busy,
  input  wire logic              in_is_ipv6,
  input  wire logic [ADDR_W-1:0] in_address_high,
  input  wire logic [ADDR_W-1:0] in_address_low,
  output      logic              out_valid,
  output      logic [2:0]        out_verdict
);

  // input stage
  logic              in_valid_r;
  logic              in_is_ipv6_r;
  logic [ADDR_W-1:0] in_hi_r;
  logic [ADDR_W-1:0] in_lo_r;

  // result stage
  logic              out_valid_r;
  verdict_t          out_verdict_r;
  verdict_t          verdict_nxt;

  // stateless and fully pipelined, so a new beat is always welcome
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= start & ~busy;
    end
  end

  // capture the address on every accepted beat
  always_ff @(posedge clk) begin
    if (start & ~busy) begin
      in_is_ipv6_r <= in_is_ipv6;
      in_hi_r      <= in_address_high;
      in_lo_r      <= in_address_low;
    end
  end

  // ipv4 looks only at the low 32 bits; ipv6 uses the full 128
  always_comb begin
    if (in_is_ipv6_r) begin
      verdict_nxt = classify_v6(in_hi_r, in_lo_r);
    end else begin
      verdict_nxt = classify_v4(in_lo_r[V4_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid_r) begin
      out_verdict_r <= verdict_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_verdict = out_verdict_r;

  // an accepted beat always reaches the input stage
  `IPDC_ASSERT_NEXT(a_accept_loads, start && !busy, in_valid_r)
  // every loaded beat produces exactly one strobe on the next cycle
  `IPDC_ASSERT_NEXT(a_load_strobes, in_valid_r, out_valid_r)
  `IPDC_ASSERT_NEXT(a_no_spurious_strobe, !in_valid_r, !out_valid_r)
  // an ipv4 address can never be judged unique-local
  `IPDC_ASSERT_NEXT(a_v4_not_ula, in_valid_r && !in_is_ipv6_r, out_verdict_r != V_UNIQUE_LOCAL)

endmodule

`default_nettype wire
